// ===== design/ffps_pkg.sv =====
// shared types, constants and arithmetic helpers for the face flux projection block
package ffps_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_FACES = 16777216;
  localparam int CNT_W     = 25;
  localparam int ACC_W     = 66;
  localparam int RES_W     = 52;
  localparam int DIV_STEPS = 2 * FRAC_BITS + 1;
  localparam int SQRT_STEPS = 32;

  typedef struct packed {
    logic signed [31:0] area_x;
    logic signed [31:0] area_y;
    logic signed [31:0] area_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] flux;
    logic               last_face;
  } ffps_item_t;

  typedef struct packed {
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic               corrected;
    logic               stats_final;
    logic [CNT_W-1:0]   face_count;
    logic [30:0]        max_abs_before;
    logic [30:0]        l2_before;
    logic signed [55:0] sum_before;
    logic [30:0]        max_abs_after;
    logic [30:0]        l2_after;
    logic signed [55:0] sum_after;
  } ffps_result_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } ffps_q_stat_t;

  typedef struct packed {
    logic             start;
    logic [RES_W-1:0] mag;
    logic [63:0]      den;
  } ffps_div_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] val;
  } ffps_sqrt_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [RES_W-1:0] x);
    logic signed [31:0] y;
    if (x > RES_W'(64'sd2147483647)) y = 32'sh7fffffff;
    else if (x < RES_W'(-64'sd2147483648)) y = 32'sh80000000;
    else y = x[31:0];
    return y;
  endfunction

  function automatic logic [30:0] mag31(input logic signed [31:0] x);
    logic [31:0] n;
    logic [30:0] m;
    n = 32'(-x);
    if (x == 32'sh80000000) m = 31'h7fffffff;
    else if (x[31]) m = n[30:0];
    else m = x[30:0];
    return m;
  endfunction

  function automatic logic signed [55:0] sat_sum56(input logic signed [55:0] s,
                                                   input logic signed [31:0] r);
    logic signed [56:0] t;
    logic signed [55:0] y;
    t = 57'(s) + 57'(r);
    if (t[56] != t[55]) y = t[56] ? {1'b1, 55'd0} : {1'b0, {55{1'b1}}};
    else y = t[55:0];
    return y;
  endfunction

  function automatic logic [63:0] sat_sq(input logic [63:0] s, input logic [63:0] p);
    logic [64:0] t;
    t = {1'b0, s} + {1'b0, p};
    return t[64] ? {64{1'b1}} : t[63:0];
  endfunction

endpackage

// ===== design/ffps_fifo.sv =====
// two-entry face queue between the accepting front and the processing engine
module ffps_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ffps_pkg::ffps_item_t  item_i,
  input  logic                  pop_i,
  output ffps_pkg::ffps_item_t  head_o,
  output ffps_pkg::ffps_q_stat_t stat_o
);

  ffps_pkg::ffps_item_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  assign head_o           = mem_q[rd_q];
  assign stat_o.not_empty = (cnt_q != 2'd0);
  assign stat_o.full      = (cnt_q == 2'd2);

endmodule

// ===== design/ffps_div.sv =====
// iterative restoring divider for the correction factor, one quotient bit a cycle
module ffps_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ffps_pkg::ffps_div_req_t req_i,
  output logic                   done_o,
  output logic [31:0]            quo_o
);

  localparam int CW = $clog2(ffps_pkg::DIV_STEPS);

  logic          busy_q, done_q, ovf_q, mag0_q;
  logic [CW-1:0] cnt_q;
  logic [63:0]   rem_q, den_q;
  logic [32:0]   quo_q;
  logic [64:0]   rem2, diff;
  logic          ge, ovf;

  assign ovf  = {13'd0, req_i.mag} >= {req_i.den, 1'b0};
  assign rem2 = {rem_q, (cnt_q == '0) ? mag0_q : 1'b0};
  assign ge   = rem2 >= {1'b0, den_q};
  assign diff = rem2 - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= ~ovf;
        done_q <= ovf;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(ffps_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ovf_q  <= ovf;
      den_q  <= req_i.den;
      rem_q  <= 64'(req_i.mag >> 1);
      mag0_q <= req_i.mag[0];
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[63:0] : rem2[63:0];
      quo_q <= {quo_q[31:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = (ovf_q || quo_q > 33'h080000000) ? 32'h80000000 : quo_q[31:0];

endmodule

// ===== design/ffps_sqrt.sv =====
// iterative integer square root, one result bit a cycle
module ffps_sqrt (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ffps_pkg::ffps_sqrt_req_t req_i,
  output logic                    done_o,
  output logic [31:0]             root_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] v_q, res_q, bit_q, trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(ffps_pkg::SQRT_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      v_q   <= req_i.val;
      res_q <= '0;
      bit_q <= 64'd1 << 62;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule

// ===== design/ffps_engine.sv =====
// back end: sequenced projection, statistics and result register
module ffps_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [30:0]            min_area_sq_i,
  input  ffps_pkg::ffps_item_t   head_i,
  input  ffps_pkg::ffps_q_stat_t q_stat_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output ffps_pkg::ffps_result_t out_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DOT   = 4'd1;
  localparam logic [3:0] S_AREA  = 4'd2;
  localparam logic [3:0] S_RSQB  = 4'd3;
  localparam logic [3:0] S_RSQB2 = 4'd4;
  localparam logic [3:0] S_DIVW  = 4'd5;
  localparam logic [3:0] S_CA    = 4'd6;
  localparam logic [3:0] S_AFTER = 4'd7;
  localparam logic [3:0] S_RA    = 4'd8;
  localparam logic [3:0] S_RSQA  = 4'd9;
  localparam logic [3:0] S_RSQA2 = 4'd10;
  localparam logic [3:0] S_SQB   = 4'd11;
  localparam logic [3:0] S_SQA   = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  localparam int RW = ffps_pkg::RES_W;

  logic [3:0] state_q;
  logic [1:0] cnt_q;
  logic       out_vld_q;

  logic signed [31:0] a_q [3];
  logic signed [31:0] v_q [3];
  logic signed [31:0] nv_q [3];
  logic signed [31:0] flux_q, c_q;
  logic               last_q, corr_q;
  logic signed [ffps_pkg::ACC_W-1:0] acc_q;
  logic [63:0]        area_q;
  logic signed [RW-1:0] r_q;
  logic signed [63:0] prod_q;
  logic [30:0]        l2b_q, l2a_q;

  logic [ffps_pkg::CNT_W-1:0] faces_q;
  logic [30:0]        peak_b_q, peak_a_q;
  logic [63:0]        sq_b_q, sq_a_q;
  logic signed [55:0] sum_b_q, sum_a_q;

  logic signed [31:0] op_a, op_b, rs, va, cq;
  logic signed [RW-1:0] r_new, nv_sum;
  logic [RW-1:0]      r_mag;
  logic               take_out, corr_d, div_done, sqrt_done;
  logic [31:0]        div_quo, root;
  ffps_pkg::ffps_div_req_t  div_req;
  ffps_pkg::ffps_sqrt_req_t sqrt_req;
  ffps_pkg::ffps_result_t   res;

  ffps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  ffps_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .done_o (sqrt_done),
    .root_o (root)
  );

  function automatic logic signed [31:0] pick(input logic signed [31:0] arr [3],
                                              input logic [1:0] idx);
    logic signed [31:0] y;
    case (idx)
      2'd0:    y = arr[0];
      2'd1:    y = arr[1];
      2'd2:    y = arr[2];
      default: y = '0;
    endcase
    return y;
  endfunction

  function automatic logic [30:0] clip31(input logic [31:0] x);
    return x[31] ? 31'h7fffffff : x[30:0];
  endfunction

  // shared multiplier operands
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      S_DOT: begin
        op_a = pick(a_q, cnt_q);
        op_b = pick(v_q, cnt_q);
      end
      S_AREA: begin
        op_a = pick(a_q, cnt_q);
        op_b = pick(a_q, cnt_q);
      end
      S_RSQB, S_RSQA: begin
        op_a = rs;
        op_b = rs;
      end
      S_CA: begin
        op_a = c_q;
        op_b = pick(a_q, cnt_q);
      end
      S_AFTER: begin
        op_a = pick(a_q, cnt_q);
        op_b = pick(nv_q, cnt_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign rs     = ffps_pkg::sat32(r_q);
  assign r_new  = RW'(acc_q >>> ffps_pkg::FRAC_BITS) - RW'(flux_q);
  assign r_mag  = r_q[RW-1] ? RW'(-r_q) : r_q;
  assign corr_d = area_q > (64'(min_area_sq_i) << ffps_pkg::FRAC_BITS);
  assign va     = (cnt_q == 2'd0) ? '0 : pick(v_q, cnt_q - 2'd1);
  assign nv_sum = RW'(va) + RW'(prod_q >>> ffps_pkg::FRAC_BITS);
  // negative residual pushes along the area vector, positive against it
  assign cq     = r_q[RW-1] ? ((div_quo == 32'h80000000) ? 32'sh7fffffff : div_quo)
                            : 32'(-div_quo);
  assign take_out = !out_vld_q || !out_stall_i;

  assign pop_o = (state_q == S_IDLE) && q_stat_i.not_empty;

  assign div_req.start = (state_q == S_RSQB2) && corr_q;
  assign div_req.mag   = r_mag;
  assign div_req.den   = area_q;

  assign sqrt_req.start = ((state_q == S_RSQA2) && last_q) ||
                          ((state_q == S_SQB) && sqrt_done);
  assign sqrt_req.val   = (state_q == S_SQB) ? sq_a_q : sq_b_q;

  always_comb begin
    res = '0;
    res.new_vel_x = nv_q[0];
    res.new_vel_y = nv_q[1];
    res.new_vel_z = nv_q[2];
    res.corrected = corr_q;
    if (last_q) begin
      res.stats_final    = 1'b1;
      res.face_count     = faces_q;
      res.max_abs_before = peak_b_q;
      res.l2_before      = l2b_q;
      res.sum_before     = sum_b_q;
      res.max_abs_after  = peak_a_q;
      res.l2_after       = l2a_q;
      res.sum_after      = sum_a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      faces_q   <= '0;
      peak_b_q  <= '0;
      peak_a_q  <= '0;
      sq_b_q    <= '0;
      sq_a_q    <= '0;
      sum_b_q   <= '0;
      sum_a_q   <= '0;
    end else begin
      if (out_vld_q && !out_stall_i) out_vld_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_stat_i.not_empty) begin
            state_q <= S_DOT;
            cnt_q   <= '0;
          end
        end
        S_DOT: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) state_q <= S_AREA;
        end
        S_AREA: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) state_q <= S_RSQB;
        end
        S_RSQB: begin
          if (ffps_pkg::mag31(rs) > peak_b_q) peak_b_q <= ffps_pkg::mag31(rs);
          sum_b_q <= ffps_pkg::sat_sum56(sum_b_q, rs);
          state_q <= S_RSQB2;
        end
        S_RSQB2: begin
          sq_b_q  <= ffps_pkg::sat_sq(sq_b_q, $unsigned(prod_q));
          cnt_q   <= '0;
          state_q <= corr_q ? S_DIVW : S_AFTER;
        end
        S_DIVW: begin
          if (div_done) begin
            state_q <= S_CA;
            cnt_q   <= '0;
          end
        end
        S_CA: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) state_q <= S_AFTER;
        end
        S_AFTER: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) state_q <= S_RA;
        end
        S_RA: state_q <= S_RSQA;
        S_RSQA: begin
          if (ffps_pkg::mag31(rs) > peak_a_q) peak_a_q <= ffps_pkg::mag31(rs);
          sum_a_q <= ffps_pkg::sat_sum56(sum_a_q, rs);
          if (faces_q < ffps_pkg::CNT_W'(ffps_pkg::MAX_FACES))
            faces_q <= faces_q + ffps_pkg::CNT_W'(1);
          state_q <= S_RSQA2;
        end
        S_RSQA2: begin
          sq_a_q  <= ffps_pkg::sat_sq(sq_a_q, $unsigned(prod_q));
          state_q <= last_q ? S_SQB : S_DONE;
        end
        S_SQB: if (sqrt_done) state_q <= S_SQA;
        S_SQA: if (sqrt_done) state_q <= S_DONE;
        S_DONE: begin
          if (take_out) begin
            out_vld_q <= 1'b1;
            state_q   <= S_IDLE;
            if (last_q) begin
              faces_q  <= '0;
              peak_b_q <= '0;
              peak_a_q <= '0;
              sq_b_q   <= '0;
              sq_a_q   <= '0;
              sum_b_q  <= '0;
              sum_a_q  <= '0;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    case (state_q)
      S_IDLE: begin
        a_q[0] <= head_i.area_x;
        a_q[1] <= head_i.area_y;
        a_q[2] <= head_i.area_z;
        v_q[0] <= head_i.vel_x;
        v_q[1] <= head_i.vel_y;
        v_q[2] <= head_i.vel_z;
        flux_q <= head_i.flux;
        last_q <= head_i.last_face;
        acc_q  <= '0;
        area_q <= '0;
      end
      S_DOT: if (cnt_q != 2'd0) acc_q <= acc_q + ffps_pkg::ACC_W'(prod_q);
      S_AREA: begin
        if (cnt_q == 2'd0) r_q <= r_new;
        else area_q <= area_q + $unsigned(prod_q);
      end
      S_RSQB: corr_q <= corr_d;
      S_RSQB2: begin
        acc_q <= '0;
        if (!corr_q) nv_q <= v_q;
      end
      S_DIVW: if (div_done) c_q <= cq;
      S_CA: begin
        if (cnt_q != 2'd0) nv_q[cnt_q - 2'd1] <= ffps_pkg::sat32(nv_sum);
        acc_q <= '0;
      end
      S_AFTER: if (cnt_q != 2'd0) acc_q <= acc_q + ffps_pkg::ACC_W'(prod_q);
      S_RA: r_q <= r_new;
      S_SQB: if (sqrt_done) l2b_q <= clip31(root);
      S_SQA: if (sqrt_done) l2a_q <= clip31(root);
      S_DONE: if (take_out) out_o <= res;
      default: ;
    endcase
  end

  assign out_valid_o = out_vld_q;

endmodule

// ===== design/face_flux_projection_stats.sv =====
// top level of the face flux projection block with residual statistics
// A shared 32x32 multiplier runs the dot products, squared area, correction
// products and residual squares of each face beat in turn, and an iterative
// divider spends 33 steps on the correction factor when the area passes the
// threshold. The face marked last adds two 32-step square roots on one shared
// unit. A two-entry queue takes new faces while one is worked on, and the
// result register holds a finished face while the next one proceeds.
module face_flux_projection_stats (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [30:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] area_x_i,
  input  logic signed [31:0] area_y_i,
  input  logic signed [31:0] area_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic signed [31:0] flux_i,
  input  logic               last_face_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] new_vel_x_o,
  output logic signed [31:0] new_vel_y_o,
  output logic signed [31:0] new_vel_z_o,
  output logic               corrected_o,
  output logic               stats_final_o,
  output logic [24:0]        face_count_o,
  output logic [30:0]        max_abs_before_o,
  output logic [30:0]        l2_before_o,
  output logic signed [55:0] sum_before_o,
  output logic [30:0]        max_abs_after_o,
  output logic [30:0]        l2_after_o,
  output logic signed [55:0] sum_after_o
);

  logic [30:0] min_area_sq_q;
  logic        push, pop;
  ffps_pkg::ffps_item_t   item, head;
  ffps_pkg::ffps_q_stat_t q_stat;
  ffps_pkg::ffps_result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_area_sq_q <= 31'd1;
    end else if (cfg_we_i) begin
      min_area_sq_q <= cfg_wdata_i;
    end
  end

  assign item.area_x    = area_x_i;
  assign item.area_y    = area_y_i;
  assign item.area_z    = area_z_i;
  assign item.vel_x     = vel_x_i;
  assign item.vel_y     = vel_y_i;
  assign item.vel_z     = vel_z_i;
  assign item.flux      = flux_i;
  assign item.last_face = last_face_i;

  assign in_stall_o = q_stat.full;
  assign push       = in_valid_i && !q_stat.full;

  ffps_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  ffps_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .min_area_sq_i (min_area_sq_q),
    .head_i        (head),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_o         (res)
  );

  assign new_vel_x_o      = res.new_vel_x;
  assign new_vel_y_o      = res.new_vel_y;
  assign new_vel_z_o      = res.new_vel_z;
  assign corrected_o      = res.corrected;
  assign stats_final_o    = res.stats_final;
  assign face_count_o     = res.face_count;
  assign max_abs_before_o = res.max_abs_before;
  assign l2_before_o      = res.l2_before;
  assign sum_before_o     = res.sum_before;
  assign max_abs_after_o  = res.max_abs_after;
  assign l2_after_o       = res.l2_after;
  assign sum_after_o      = res.sum_after;

`ifndef ASSERT_OFF
  a_final_has_faces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stats_final_o |-> face_count_o != 25'd0)
    else $error("final statistics with no faces");

  a_plain_no_stats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !stats_final_o |-> face_count_o == 25'd0 && sum_before_o == 56'sd0)
    else $error("statistics shown on a face that is not last");

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_stat.not_empty |-> !in_stall_o)
    else $error("stall with empty queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_stat.not_empty)
    else $error("queue popped while empty");
`endif

endmodule

// ===== bench/tb_face_flux_projection_stats.sv =====
// self-checking testbench for the face flux projection and residual statistics block
module tb_face_flux_projection_stats;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic [30:0] peak;
    logic [63:0] sq;
    longint      sum;
  } resid_stats_t;

  localparam longint SUM56_MAX = 64'sd36028797018963967;
  localparam longint SUM56_MIN = -64'sd36028797018963968;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [30:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  ffps_pkg::ffps_item_t face_drv = '0;
  ffps_pkg::ffps_result_t res_dut;

  ffps_pkg::ffps_item_t   pending_faces[$];
  ffps_pkg::ffps_result_t expected_results[$];
  idle_mode_e   idle_mode = IDLE_NONE;
  int           rx_hold_left = 0;
  int           errors = 0;
  logic         face_took = 1'b0;

  // model state
  logic [30:0]  area_thr;
  logic [24:0]  faces_seen;
  resid_stats_t st_before, st_after;

  always #5 clk_i = ~clk_i;

  face_flux_projection_stats dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o,
    .area_x_i(face_drv.area_x), .area_y_i(face_drv.area_y), .area_z_i(face_drv.area_z),
    .vel_x_i(face_drv.vel_x), .vel_y_i(face_drv.vel_y), .vel_z_i(face_drv.vel_z),
    .flux_i(face_drv.flux), .last_face_i(face_drv.last_face),
    .out_valid_o, .out_stall_i,
    .new_vel_x_o(res_dut.new_vel_x), .new_vel_y_o(res_dut.new_vel_y),
    .new_vel_z_o(res_dut.new_vel_z), .corrected_o(res_dut.corrected),
    .stats_final_o(res_dut.stats_final), .face_count_o(res_dut.face_count),
    .max_abs_before_o(res_dut.max_abs_before), .l2_before_o(res_dut.l2_before),
    .sum_before_o(res_dut.sum_before), .max_abs_after_o(res_dut.max_abs_after),
    .l2_after_o(res_dut.l2_after), .sum_after_o(res_dut.sum_after)
  );

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // exact sum of products, floored to the fraction bits
  function automatic longint floor_dot(logic signed [31:0] a0, a1, a2, b0, b1, b2);
    logic signed [69:0] s;
    s = 70'(a0) * 70'(b0) + 70'(a1) * 70'(b1) + 70'(a2) * 70'(b2);
    s = s >>> ffps_pkg::FRAC_BITS;
    return s[63:0];
  endfunction

  function automatic resid_stats_t fold_residual(resid_stats_t s, logic signed [31:0] r);
    longint rl, m, t;
    logic [64:0] sq;
    rl = r;
    m = (rl < 0) ? -rl : rl;
    if (m > 64'sd2147483647) m = 64'sd2147483647;
    if (m[30:0] > s.peak) s.peak = m[30:0];
    sq = {1'b0, s.sq} + {1'b0, 64'(rl * rl)};
    s.sq = sq[64] ? {64{1'b1}} : sq[63:0];
    t = s.sum + rl;
    if (t > SUM56_MAX) t = SUM56_MAX;
    if (t < SUM56_MIN) t = SUM56_MIN;
    s.sum = t;
    return s;
  endfunction

  function automatic logic [30:0] root31(logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return (res > 64'h7fffffff) ? 31'h7fffffff : res[30:0];
  endfunction

  function automatic ffps_pkg::ffps_result_t project_face(ffps_pkg::ffps_item_t f);
    ffps_pkg::ffps_result_t o;
    logic [63:0] area_sq;
    logic [127:0] q;
    longint dot, r, mag, c;
    logic signed [31:0] nv[3], av[3];
    o = '0;
    av = '{f.area_x, f.area_y, f.area_z};
    nv = '{f.vel_x, f.vel_y, f.vel_z};
    area_sq = 64'(longint'(f.area_x) * f.area_x) + 64'(longint'(f.area_y) * f.area_y)
            + 64'(longint'(f.area_z) * f.area_z);
    dot = floor_dot(f.area_x, f.area_y, f.area_z, f.vel_x, f.vel_y, f.vel_z);
    r = dot - longint'(f.flux);
    st_before = fold_residual(st_before, clip32(r));
    if (area_sq > (64'(area_thr) << ffps_pkg::FRAC_BITS)) begin
      mag = (r < 0) ? -r : r;
      q = (128'(mag) << (2 * ffps_pkg::FRAC_BITS)) / 128'(area_sq);
      if (q > 128'h80000000) q = 128'h80000000;
      // correction factor has the sign of -r
      c = (r > 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
      c = clip32(c);
      for (int i = 0; i < 3; i++)
        nv[i] = clip32(longint'(nv[i]) + ((c * av[i]) >>> ffps_pkg::FRAC_BITS));
      o.corrected = 1'b1;
    end
    st_after = fold_residual(st_after,
      clip32(floor_dot(f.area_x, f.area_y, f.area_z, nv[0], nv[1], nv[2]) - longint'(f.flux)));
    if (faces_seen < ffps_pkg::MAX_FACES) faces_seen++;
    o.new_vel_x = nv[0];
    o.new_vel_y = nv[1];
    o.new_vel_z = nv[2];
    if (f.last_face) begin
      o.stats_final = 1'b1;
      o.face_count = faces_seen;
      o.max_abs_before = st_before.peak;
      o.l2_before = root31(st_before.sq);
      o.sum_before = st_before.sum[55:0];
      o.max_abs_after = st_after.peak;
      o.l2_after = root31(st_after.sq);
      o.sum_after = st_after.sum[55:0];
      faces_seen = '0;
      st_before = '{default: '0};
      st_after = '{default: '0};
    end
    return o;
  endfunction

  function automatic logic signed [31:0] extreme32();
    case ($urandom_range(4))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic logic signed [31:0] around(int unsigned span);
    return $signed($urandom_range(2 * span)) - $signed(span);
  endfunction

  function automatic ffps_pkg::ffps_item_t random_face();
    ffps_pkg::ffps_item_t f;
    int unsigned kind, as, vs;
    kind = $urandom_range(9);
    case (kind)
      6: begin
        f = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0};
      end
      7: begin
        f = '{extreme32(), extreme32(), extreme32(), extreme32(), extreme32(),
              extreme32(), extreme32(), 1'b0};
      end
      default: begin
        // physically sensible faces, with tiny and huge areas mixed in
        as = (kind == 8) ? 400 : (kind == 9) ? 32'h02000000 : 32'h00040000;
        vs = 32'h00400000;
        f.area_x = around(as);
        f.area_y = around(as);
        f.area_z = around(as);
        f.vel_x = around(vs);
        f.vel_y = around(vs);
        f.vel_z = around(vs);
        f.flux = ($urandom_range(3) == 0) ? $urandom : around(32'h01000000);
      end
    endcase
    f.last_face = ($urandom_range(9) == 0);
    return f;
  endfunction

  function automatic ffps_pkg::ffps_item_t make_face(logic signed [31:0] ax, ay, az,
                                                     vx, vy, vz, fl, logic lst);
    return '{ax, ay, az, vx, vy, vz, fl, lst};
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %h actual %h at %0t", name, want, got, $realtime);
    end
  endtask

  // input side: acceptance and prediction at the rising edge
  always @(posedge clk_i) begin
    face_took <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      expected_results.push_back(project_face(face_drv));
      void'(pending_faces.pop_front());
    end
  end

  // face driver: new beat or idle at the falling edge
  always @(negedge clk_i) begin
    if (!in_valid_i || face_took) begin
      if (pending_faces.size() > 0 &&
          !((idle_mode == IDLE_TX && $urandom_range(99) < 48) ||
            (idle_mode == IDLE_BOTH && $urandom_range(99) < 6))) begin
        face_drv <= pending_faces[0];
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result stall: long hold-off or random stalls
  always @(negedge clk_i)
    out_stall_i <= (rx_hold_left > 0) ||
                   (idle_mode == IDLE_RX && $urandom_range(99) < 48) ||
                   (idle_mode == IDLE_BOTH && $urandom_range(99) < 6);

  always @(posedge clk_i)
    if (rx_hold_left > 0) rx_hold_left <= rx_hold_left - 1;

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        ffps_pkg::ffps_result_t w;
        w = expected_results.pop_front();
        check_field("new_vel_x", 64'(w.new_vel_x), 64'(res_dut.new_vel_x));
        check_field("new_vel_y", 64'(w.new_vel_y), 64'(res_dut.new_vel_y));
        check_field("new_vel_z", 64'(w.new_vel_z), 64'(res_dut.new_vel_z));
        check_field("corrected", 64'(w.corrected), 64'(res_dut.corrected));
        check_field("stats_final", 64'(w.stats_final), 64'(res_dut.stats_final));
        check_field("face_count", 64'(w.face_count), 64'(res_dut.face_count));
        check_field("max_abs_before", 64'(w.max_abs_before), 64'(res_dut.max_abs_before));
        check_field("l2_before", 64'(w.l2_before), 64'(res_dut.l2_before));
        check_field("sum_before", 64'(w.sum_before), 64'(res_dut.sum_before));
        check_field("max_abs_after", 64'(w.max_abs_after), 64'(res_dut.max_abs_after));
        check_field("l2_after", 64'(w.l2_after), 64'(res_dut.l2_after));
        check_field("sum_after", 64'(w.sum_after), 64'(res_dut.sum_after));
      end
    end
  end

  task automatic drain_faces();
    wait (pending_faces.size() == 0 && expected_results.size() == 0);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [30:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    area_thr = v;
  endtask

  task automatic random_phase(int n, idle_mode_e m, logic [30:0] thr);
    drain_faces();
    write_threshold(thr);
    idle_mode = m;
    repeat (n) pending_faces.push_back(random_face());
    pending_faces.push_back(random_face());
    pending_faces[$].last_face = 1'b1;
  endtask

  initial begin
    area_thr = 31'd1;
    faces_seen = '0;
    st_before = '{default: '0};
    st_after = '{default: '0};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed faces with the reset threshold
    pending_faces.push_back(make_face(0, 0, 0, 32'sh10000, 5, -7, 32'sh20000, 1'b0));
    pending_faces.push_back(make_face(256, 0, 0, 32'sh10000, 0, 0, 32'sh50000, 1'b0));
    pending_faces.push_back(make_face(257, 0, 0, 32'sh10000, 0, 0, 32'sh50000, 1'b0));
    pending_faces.push_back(make_face(32'sh10000, 0, 0, 32'sh30000, 32'sh7000, 1,
                                      32'sh10000, 1'b0));
    pending_faces.push_back(make_face(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                      32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b0));
    pending_faces.push_back(make_face(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                      32'sh80000000, 32'sh80000000, 32'sh80000000,
                                      32'sh7fffffff, 1'b0));
    pending_faces.push_back(make_face(32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff,
                                      32'sh80000000, -1, 32'sh80000000, 1'b1));
    pending_faces.push_back(make_face(1, -1, 1, -1, 1, -1, 0, 1'b1));
    pending_faces.push_back(make_face(-32'sh18000, 32'sh8000, -32'sh4000, -32'sh40000,
                                      32'sh123456, -32'sh9876, -32'sh7fffffff, 1'b0));
    pending_faces.push_back(make_face(3, 0, 0, 32'sh7fffffff, 0, 0, 32'sh80000000, 1'b0));
    pending_faces.push_back(make_face(32'sh1000000, 32'sh1000000, 0, -32'sh200000, 32'sh11,
                                      32'sh7fffffff, 32'sh7fffffff, 1'b0));
    pending_faces.push_back(make_face(-32'sh10000, -32'sh10000, -32'sh10000, 32'sh10000,
                                      32'sh10000, 32'sh10000, -32'sh30000, 1'b1));
    drain_faces();
    // zero threshold: any nonzero area is corrected
    write_threshold(31'd0);
    pending_faces.push_back(make_face(1, 0, 0, 32'sh10000, 0, 0, 32'sh10000, 1'b0));
    pending_faces.push_back(make_face(0, 0, 0, 32'sh10000, 0, 0, 32'sh10000, 1'b1));
    // top threshold: only very large areas pass
    drain_faces();
    write_threshold(31'h7fffffff);
    pending_faces.push_back(make_face(32'sh1000000, 0, 0, 32'sh10000, 0, 0, 0, 1'b0));
    pending_faces.push_back(make_face(32'sh1000001, 32'sh7fffffff, 0, 32'sh10000, 5, 0, 0,
                                      1'b0));
    pending_faces.push_back(make_face(32'sh800000, 32'sh800000, 0, 32'sh10000, 0, 0, 0, 1'b1));

    random_phase(80, IDLE_NONE, 31'd1);
    random_phase(80, IDLE_TX, 31'h7fffffff);
    random_phase(80, IDLE_RX, 31'($urandom_range(32'h7fffffff)));
    random_phase(80, IDLE_BOTH, 31'd0);
    // receiver holds off while faces keep coming, so the input backs up
    random_phase(80, IDLE_NONE, 31'($urandom_range(32'h10000)));
    @(negedge clk_i);
    rx_hold_left <= 400;
    drain_faces();

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
